>>> sv/fpts_pkg.sv
// Package with shared types and constants for the flash page transfer splitter.
package fpts_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned CountW = 13;
  localparam int unsigned LenW   = 11;

  localparam logic [CountW-1:0] MaxCount      = 13'd4096;
  localparam logic [4:0]        MaxChunks     = 5'd17;
  localparam logic [LenW-1:0]   PageSizeMax   = 11'd1024;
  localparam logic [LenW-1:0]   PageSizeReset = 11'd528;
  localparam logic [7:0]        OpProgram     = 8'h82;
  localparam logic [7:0]        OpRead        = 8'hD2;

  typedef struct packed {
    logic [AddrW-1:0]  start_address;
    logic [CountW-1:0] byte_count;
    logic              is_write;
  } req_t;

  typedef struct packed {
    logic [7:0]       page_opcode;
    logic [AddrW-1:0] chunk_address;
    logic [LenW-1:0]  chunk_length;
    logic             last_chunk;
  } res_t;

  typedef enum logic [1:0] {
    StIdle,
    StMod,
    StEmit
  } state_e;

endpackage

>>> sv/flash_page_transfer_splitter_unit.sv
// Top level of the flash page transfer splitter: splits a transfer at page boundaries.
//
// Usage:
//   A transfer request (start address, byte count, direction) is taken at a rising
//   edge where start is high and busy is low. The block first finds the page offset
//   of the start address with a restoring remainder loop, one address bit per cycle
//   through a shared subtractor. It then emits one chunk per cycle on result_o,
//   marked by result_valid_o for exactly one cycle; the last chunk carries last_chunk.
//   Busy stays high through the remainder loop and the emit phase, and a request
//   yields at most 17 chunks. A request with a zero byte count produces no chunk and
//   leaves the block idle at once. The page size register is written with cfg_we_i /
//   cfg_wdata_i; the user must write it only while idle, which the block does not
//   enforce. It resets to 528, zero acts as 1 and values above 1024 act as 1024.
//   The receiver cannot stall: each chunk must be taken in the cycle it is shown.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle, drops any
//   transfer in progress and restores the page size.
module flash_page_transfer_splitter_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  fpts_pkg::req_t            req_i,
  input  logic                      cfg_we_i,
  input  logic [fpts_pkg::LenW-1:0] cfg_wdata_i,
  output logic                      result_valid_o,
  output fpts_pkg::res_t            result_o
);

  fpts_pkg::state_e state_q, state_d;

  logic [fpts_pkg::LenW-1:0]   page_q;
  logic [fpts_pkg::LenW-1:0]   psize;
  logic [fpts_pkg::AddrW-1:0]  addr_q, addr_d;
  logic [fpts_pkg::CountW-1:0] remain_q, remain_d;
  logic                        wr_q, wr_d;
  logic [fpts_pkg::LenW-1:0]   off_q, off_d;
  logic [4:0]                  bit_q, bit_d;
  logic [4:0]                  chunk_q, chunk_d;
  logic                        valid_q, valid_d;
  fpts_pkg::res_t              res_q, res_d;

  // Shared subtractor
  logic [fpts_pkg::LenW-1:0] sub_a, sub_b;
  logic [fpts_pkg::LenW:0]   sub_res;

  logic [fpts_pkg::LenW-1:0]   shifted;
  logic [fpts_pkg::LenW-1:0]   room;
  logic [fpts_pkg::LenW-1:0]   len;
  logic [fpts_pkg::CountW-1:0] remain_nx;
  logic [fpts_pkg::AddrW:0]    addr_sum;
  logic                        last;
  logic [fpts_pkg::CountW-1:0] count_sat;

  // Clamp page size to the legal range
  always_comb begin
    if (page_q == '0) begin
      psize = fpts_pkg::LenW'(1);
    end else if (page_q > fpts_pkg::PageSizeMax) begin
      psize = fpts_pkg::PageSizeMax;
    end else begin
      psize = page_q;
    end
  end

  assign count_sat = (req_i.byte_count > fpts_pkg::MaxCount) ? fpts_pkg::MaxCount
                                                             : req_i.byte_count;

  // Remainder step operand: shift in the next address bit
  assign shifted = {off_q[fpts_pkg::LenW-2:0], addr_q[bit_q]};

  // Route operands into the shared subtractor
  always_comb begin
    if (state_q == fpts_pkg::StMod) begin
      sub_a = shifted;
      sub_b = psize;
    end else begin
      sub_a = psize;
      sub_b = off_q;
    end
  end

  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};

  // Chunk sizing for the emit phase
  assign room      = sub_res[fpts_pkg::LenW-1:0];
  assign len       = (remain_q < {2'b00, room}) ? remain_q[fpts_pkg::LenW-1:0] : room;
  assign remain_nx = remain_q - {2'b00, len};
  assign last      = (remain_nx == '0) || (chunk_q == fpts_pkg::MaxChunks - 5'd1);
  assign addr_sum  = {1'b0, addr_q} + {{(fpts_pkg::AddrW-fpts_pkg::LenW+1){1'b0}}, len};

  // Next state and datapath control
  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    remain_d = remain_q;
    wr_d     = wr_q;
    off_d    = off_q;
    bit_d    = bit_q;
    chunk_d  = chunk_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    unique case (state_q)
      fpts_pkg::StIdle: begin
        if (start) begin
          addr_d   = req_i.start_address;
          remain_d = count_sat;
          wr_d     = req_i.is_write;
          off_d    = '0;
          bit_d    = 5'(fpts_pkg::AddrW - 1);
          chunk_d  = '0;
          if (count_sat != '0) begin
            state_d = fpts_pkg::StMod;
          end
        end
      end
      fpts_pkg::StMod: begin
        off_d = sub_res[fpts_pkg::LenW] ? shifted : sub_res[fpts_pkg::LenW-1:0];
        bit_d = bit_q - 5'd1;
        if (bit_q == '0) begin
          state_d = fpts_pkg::StEmit;
        end
      end
      fpts_pkg::StEmit: begin
        valid_d             = 1'b1;
        res_d.page_opcode   = wr_q ? fpts_pkg::OpProgram : fpts_pkg::OpRead;
        res_d.chunk_address = addr_q;
        res_d.chunk_length  = len;
        res_d.last_chunk    = last;
        addr_d              = addr_sum[fpts_pkg::AddrW-1:0];
        remain_d            = remain_nx;
        chunk_d             = chunk_q + 5'd1;
        // After a wrap past the top of the address space the offset is the
        // wrapped address itself, which is always below one page.
        off_d = addr_sum[fpts_pkg::AddrW] ? addr_sum[fpts_pkg::LenW-1:0] : '0;
        if (last) begin
          state_d = fpts_pkg::StIdle;
        end
      end
      default: begin
        state_d = fpts_pkg::StIdle;
      end
    endcase
  end

  // Hold control state and the page size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpts_pkg::StIdle;
      valid_q <= 1'b0;
      page_q  <= fpts_pkg::PageSizeReset;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        page_q <= cfg_wdata_i;
      end
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    remain_q <= remain_d;
    wr_q     <= wr_d;
    off_q    <= off_d;
    bit_q    <= bit_d;
    chunk_q  <= chunk_d;
    res_q    <= res_d;
  end

  assign busy           = (state_q != fpts_pkg::StIdle);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  // Checks
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.chunk_length != '0))
    else $error("chunk of zero length emitted");

  a_len_fits_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.chunk_length <= psize))
    else $error("chunk longer than a page");

  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_chunk) |=> !result_valid_o)
    else $error("chunk emitted after the last chunk");

  a_quiet_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !result_valid_o)
    else $error("chunk emitted without a transfer in progress");

  a_chunk_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpts_pkg::StEmit) |-> (chunk_q < fpts_pkg::MaxChunks))
    else $error("chunk count past the limit");

endmodule

>>> dv/flash_page_transfer_splitter_unit_tb.sv
// Self-checking testbench for the flash page transfer splitter: directed table, then random phases.
module flash_page_transfer_splitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Source of the expected chunks for one request
  typedef enum logic [1:0] {
    ChkPredict,
    ChkNone,
    ChkOne
  } chk_e;

  typedef struct packed {
    logic [fpts_pkg::LenW-1:0] page;
    fpts_pkg::req_t            req;
    chk_e                      kind;
    fpts_pkg::res_t            chunk;
  } dir_row_t;

  localparam int NumRows       = 23;
  localparam int NumPhases     = 9;
  localparam int ItemsPerPhase = 26;
  localparam int SettleCycles  = 48;
  localparam int WatchdogLimit = 2000;

  // Directed requests; typed chunks only where the answer is obvious
  localparam dir_row_t DirRows [NumRows] = '{
    // reset page size, single byte read
    '{11'd528,  '{24'h000000, 13'd1,    1'b0}, ChkOne,
      '{fpts_pkg::OpRead,    24'h000000, 11'd1,    1'b1}},
    '{11'd528,  '{24'h00020F, 13'd2,    1'b1}, ChkPredict, '0},
    '{11'd528,  '{24'h000000, 13'd528,  1'b1}, ChkOne,
      '{fpts_pkg::OpProgram, 24'h000000, 11'd528,  1'b1}},
    // zero byte count yields nothing
    '{11'd528,  '{24'h123456, 13'd0,    1'b1}, ChkNone,    '0},
    '{11'd1024, '{24'h000000, 13'd1024, 1'b0}, ChkOne,
      '{fpts_pkg::OpRead,    24'h000000, 11'd1024, 1'b1}},
    // byte count above the maximum saturates
    '{11'd1024, '{24'h000000, 13'd8191, 1'b1}, ChkPredict, '0},
    '{11'd1024, '{24'hFFFFFF, 13'd1,    1'b1}, ChkOne,
      '{fpts_pkg::OpProgram, 24'hFFFFFF, 11'd1,    1'b1}},
    '{11'd1024, '{24'hFFFF00, 13'd4096, 1'b0}, ChkPredict, '0},
    // page size above the maximum saturates
    '{11'd2047, '{24'h0003FF, 13'd1,    1'b0}, ChkOne,
      '{fpts_pkg::OpRead,    24'h0003FF, 11'd1,    1'b1}},
    '{11'd2047, '{24'h000400, 13'd4097, 1'b1}, ChkPredict, '0},
    // page size zero acts as one: truncation after the chunk limit
    '{11'd0,    '{24'h000000, 13'd4096, 1'b1}, ChkPredict, '0},
    '{11'd0,    '{24'hABCDEF, 13'd1,    1'b0}, ChkOne,
      '{fpts_pkg::OpRead,    24'hABCDEF, 11'd1,    1'b1}},
    '{11'd1,    '{24'hFFFFF8, 13'd17,   1'b0}, ChkPredict, '0},
    '{11'd1,    '{24'h000010, 13'd18,   1'b1}, ChkPredict, '0},
    '{11'd256,  '{24'h000000, 13'd4096, 1'b1}, ChkPredict, '0},
    '{11'd256,  '{24'h000001, 13'd4096, 1'b0}, ChkPredict, '0},
    // address wraps across the top of the space
    '{11'd256,  '{24'hFFFFF0, 13'd32,   1'b1}, ChkPredict, '0},
    '{11'd264,  '{24'h001000, 13'd1000, 1'b0}, ChkPredict, '0},
    '{11'd264,  '{24'h00FFFF, 13'd4095, 1'b1}, ChkPredict, '0},
    '{11'd512,  '{24'h555555, 13'h1555, 1'b0}, ChkPredict, '0},
    '{11'd512,  '{24'hAAAAAA, 13'h0AAA, 1'b1}, ChkPredict, '0},
    '{11'd1023, '{24'h7FFFFF, 13'd2047, 1'b0}, ChkPredict, '0},
    '{11'd2,    '{24'h000001, 13'h1000, 1'b1}, ChkPredict, '0}
  };

  // Page size register values per random phase; the last phase picks its own
  localparam logic [fpts_pkg::LenW-1:0] PhasePages [NumPhases] = '{
    11'd264, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd512, 11'd5, 11'd256, 11'd528
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  fpts_pkg::req_t            req_i;
  logic                      cfg_we_i;
  logic [fpts_pkg::LenW-1:0] cfg_wdata_i;
  logic                      result_valid_o;
  fpts_pkg::res_t            result_o;

  // Driver-side tags for the request on the bus
  chk_e                      row_kind;
  fpts_pkg::res_t            row_chunk;
  logic [fpts_pkg::LenW-1:0] cur_page;

  // Predictor state and bookkeeping
  logic [fpts_pkg::LenW-1:0] page_reg = fpts_pkg::PageSizeReset;
  fpts_pkg::res_t            pending_chunks[$];
  int                        n_errors      = 0;
  int                        n_transfers   = 0;
  int                        n_chunks      = 0;
  int                        n_page_writes = 0;
  int                        stall_cycles  = 0;

  flash_page_transfer_splitter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_page(logic [fpts_pkg::LenW-1:0] reg_val);
    if (reg_val == '0) return 1;
    if (reg_val > fpts_pkg::PageSizeMax) return fpts_pkg::PageSizeMax;
    return reg_val;
  endfunction

  // Cut one request into page-bounded chunks and queue them
  function automatic void split_request(fpts_pkg::req_t rq);
    int unsigned                page;
    int unsigned                left;
    int unsigned                room;
    int unsigned                len;
    int unsigned                n;
    logic [fpts_pkg::AddrW-1:0] addr;
    fpts_pkg::res_t             ch;
    page = eff_page(page_reg);
    addr = rq.start_address;
    left = (rq.byte_count > fpts_pkg::MaxCount) ? fpts_pkg::MaxCount : rq.byte_count;
    n    = 0;
    while (left != 0 && n < fpts_pkg::MaxChunks) begin
      room = page - (addr % page);
      len  = (left < room) ? left : room;
      left -= len;
      ch.page_opcode   = rq.is_write ? fpts_pkg::OpProgram : fpts_pkg::OpRead;
      ch.chunk_address = addr;
      ch.chunk_length  = fpts_pkg::LenW'(len);
      ch.last_chunk    = (left == 0) || (n == fpts_pkg::MaxChunks - 1);
      pending_chunks.push_back(ch);
      addr = addr + fpts_pkg::AddrW'(len);
      n++;
    end
  endfunction

  function automatic void flag_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  function automatic void check_chunk(fpts_pkg::res_t got);
    fpts_pkg::res_t want;
    if (pending_chunks.size() == 0) begin
      $display("%0t ns: unexpected chunk, expected none, got addr 0x%0h len %0d",
               $time, got.chunk_address, got.chunk_length);
      n_errors++;
    end else begin
      want = pending_chunks.pop_front();
      flag_field("page_opcode", want.page_opcode, got.page_opcode);
      flag_field("chunk_address", want.chunk_address, got.chunk_address);
      flag_field("chunk_length", want.chunk_length, got.chunk_length);
      flag_field("last_chunk", want.last_chunk, got.last_chunk);
    end
  endfunction

  // Shape a random request around page boundaries and count limits
  function automatic fpts_pkg::req_t rand_request(int unsigned page);
    fpts_pkg::req_t rq;
    int unsigned    span;
    rq.start_address = fpts_pkg::AddrW'($urandom);
    case ($urandom_range(0, 7))
      0, 1: begin
        rq.start_address = rq.start_address - fpts_pkg::AddrW'(rq.start_address % page);
        if ($urandom_range(0, 1)) begin
          rq.start_address = rq.start_address + fpts_pkg::AddrW'(page - 1);
        end
      end
      2: rq.start_address = fpts_pkg::AddrW'(24'hFFFFFF - $urandom_range(0, 2 * page));
      default: ;
    endcase
    case ($urandom_range(0, 15))
      0: rq.byte_count = '0;
      1: rq.byte_count = fpts_pkg::CountW'($urandom_range(int'(fpts_pkg::MaxCount) + 1, 8191));
      2, 3, 4, 5: rq.byte_count = fpts_pkg::CountW'($urandom_range(1, 2 * page));
      6, 7, 8: begin
        span = page * $urandom_range(1, fpts_pkg::MaxChunks);
        if (span > fpts_pkg::MaxCount) span = fpts_pkg::MaxCount;
        rq.byte_count = fpts_pkg::CountW'(span);
      end
      default: rq.byte_count = fpts_pkg::CountW'($urandom_range(1, fpts_pkg::MaxCount));
    endcase
    rq.is_write = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_request(fpts_pkg::req_t rq, int gap, chk_e kind, fpts_pkg::res_t chunk);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    req_i     = rq;
    row_kind  = kind;
    row_chunk = chunk;
    start     = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Hold off until every chunk is in and the block has settled
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_chunks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_page(logic [fpts_pkg::LenW-1:0] val);
    drain();
    cfg_wdata_i = val;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cur_page = val;
    n_page_writes++;
  endtask

  // Predict on each accepted request, check each chunk, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) page_reg = cfg_wdata_i;
      if (start && busy === 1'b0) begin
        n_transfers++;
        case (row_kind)
          ChkPredict: split_request(req_i);
          ChkOne:     pending_chunks.push_back(row_chunk);
          default: ;
        endcase
      end
      if (result_valid_o === 1'b1) begin
        n_chunks++;
        check_chunk(result_o);
      end
      if ((start && busy === 1'b0) || result_valid_o === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t ns: no transfer for %0d cycles", $time, WatchdogLimit);
        $display("[flash_page_transfer_splitter_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    fpts_pkg::req_t            rq;
    logic [fpts_pkg::LenW-1:0] pg;
    int unsigned               page;
    int                        sent;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    row_kind    = ChkPredict;
    row_chunk   = '0;
    cur_page    = fpts_pkg::PageSizeReset;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table
    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].page != cur_page) write_page(DirRows[i].page);
      send_request(DirRows[i].req, 0, DirRows[i].kind, DirRows[i].chunk);
    end

    // Random phases, one page size each; every third phase runs without gaps
    for (int ph = 0; ph < NumPhases; ph++) begin
      pg = (ph == NumPhases - 1) ? fpts_pkg::LenW'($urandom_range(1, 2047)) : PhasePages[ph];
      write_page(pg);
      page = eff_page(pg);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        rq = rand_request(page);
        send_request(rq, (ph % 3 == 0) ? 0 : rand_gap(), ChkPredict, '0);
        if (rq.byte_count != 0) begin
          sent++;
          if (sent == ItemsPerPhase / 2) drain();
        end
      end
    end

    drain();
    $display("Run covered %0d transfers split into %0d chunks, %0d page size writes",
             n_transfers, n_chunks, n_page_writes);
    if (n_errors == 0) begin
      $display("[flash_page_transfer_splitter_unit] OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[flash_page_transfer_splitter_unit] ERROR");
    end
    $finish;
  end

endmodule
